[rtl/smd_pkg.sv]
package smd_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_SPAN_DEF    = 5;
  localparam int SAMPLE_BITS_DEF = 24;

  // Configuration register
  localparam int CFG_BITS   = 3;
  localparam int SPAN_RESET = 4;

  // Commands from controller to datapath
  typedef struct packed {
    logic take;        // request accepted: shift sample into window
    logic load;        // copy window into sort array
    logic step_clear;  // zero the step counter
    logic step_inc;    // advance the step counter
    logic sort;        // one odd-even transposition pass
    logic align;       // shift sort array down by one
    logic pick;        // form median and result into output register
  } smd_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic full;        // window holds span+1 samples of this block
    logic sort_last;   // current pass is the final one
    logic align_done;  // low middle element sits at index 0
    logic out_free;    // output register can take a new result
  } smd_stat_t;

endpackage

[rtl/smd_ctrl.sv]
module smd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  smd_pkg::smd_stat_t stat,
  output smd_pkg::smd_cmd_t  cmd
);
  import smd_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CHECK = 5'b00010,
    S_SORT  = 5'b00100,
    S_ALIGN = 5'b01000,
    S_PICK  = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.full) begin
          cmd.load       = 1'b1;
          cmd.step_clear = 1'b1;
          state_next     = S_SORT;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_SORT: begin
        cmd.sort = 1'b1;
        if (stat.sort_last) begin
          cmd.step_clear = 1'b1;
          state_next     = S_ALIGN;
        end else begin
          cmd.step_inc = 1'b1;
        end
      end
      S_ALIGN: begin
        if (stat.align_done) begin
          state_next = S_PICK;
        end else begin
          cmd.align    = 1'b1;
          cmd.step_inc = 1'b1;
        end
      end
      S_PICK: begin
        // hold here while the previous result is still unread
        if (stat.out_free) begin
          cmd.pick   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[rtl/smd_dp.sv]
module smd_dp #(
  parameter int MAX_SPAN    = smd_pkg::MAX_SPAN_DEF,
  parameter int SAMPLE_BITS = smd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [smd_pkg::CFG_BITS-1:0]        cfg_wdata,
  input  logic signed [SAMPLE_BITS-1:0]       sample,
  input  logic                                new_block,
  input  smd_pkg::smd_cmd_t                   cmd,
  output smd_pkg::smd_stat_t                  stat,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [SAMPLE_BITS+1:0]       detrended_half,
  output logic signed [SAMPLE_BITS:0]         median_twice
);
  import smd_pkg::*;

  localparam int DEPTH    = MAX_SPAN + 1;
  localparam int SPAN_W   = $clog2(DEPTH);
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int MED_BITS = SAMPLE_BITS + 1;
  localparam int DET_BITS = SAMPLE_BITS + 2;
  localparam int SPAN_RST = (SPAN_RESET > MAX_SPAN) ? MAX_SPAN : SPAN_RESET;
  // Pads slots beyond the window; sorts above every real sample
  localparam logic signed [MED_BITS-1:0] PAD = {1'b0, {SAMPLE_BITS{1'b1}}};

  logic [SPAN_W-1:0]                 span;
  logic [CNT_W-1:0]                  fill;
  logic [SPAN_W-1:0]                 step;
  logic signed [SAMPLE_BITS-1:0]     win [DEPTH];
  logic signed [SAMPLE_BITS-1:0]     cur;
  logic signed [MED_BITS-1:0]        srt      [DEPTH];
  logic signed [MED_BITS-1:0]        srt_next [DEPTH];
  logic [SPAN_W-1:0]                 half;
  logic signed [MED_BITS-1:0]        med2;
  logic signed [DET_BITS-1:0]        det;

  // Span register, saturating writes
  always_ff @(posedge clk) begin
    if (rst) begin
      span <= SPAN_W'(SPAN_RST);
    end else if (cfg_we) begin
      if (int'(cfg_wdata) > MAX_SPAN) begin
        span <= SPAN_W'(MAX_SPAN);
      end else begin
        span <= SPAN_W'(cfg_wdata);
      end
    end
  end

  // Fill count, restarts on a new block
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (cmd.take) begin
      if (new_block) begin
        fill <= CNT_W'(1);
      end else if (fill < CNT_W'(DEPTH)) begin
        fill <= fill + CNT_W'(1);
      end
    end
  end

  // Window shift line, newest at index 0
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      win[0] <= sample;
      for (int i = 1; i < DEPTH; i++) begin
        win[i] <= win[i-1];
      end
      cur <= sample;
    end
  end

  // Step counter for sort passes and alignment shifts
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else if (cmd.step_clear) begin
      step <= '0;
    end else if (cmd.step_inc) begin
      step <= step + SPAN_W'(1);
    end
  end

  // Sort array: load, transposition pass, or shift down
  always_comb begin
    srt_next = srt;
    if (cmd.load) begin
      for (int i = 0; i < DEPTH; i++) begin
        if (SPAN_W'(i) <= span) begin
          srt_next[i] = MED_BITS'(win[i]);
        end else begin
          srt_next[i] = PAD;
        end
      end
    end else if (cmd.sort) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        if (((i % 2) == int'(step[0])) && (srt[i] > srt[i+1])) begin
          srt_next[i]   = srt[i+1];
          srt_next[i+1] = srt[i];
        end
      end
    end else if (cmd.align) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        srt_next[i] = srt[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    srt <= srt_next;
  end

  // Low middle index of the window
  assign half = span >> 1;

  // Odd window (even span) doubles the middle; even window adds the pair
  assign med2 = span[0] ? (srt[0] + srt[1]) : (srt[0] + srt[0]);
  assign det  = DET_BITS'($signed({cur, 1'b0})) - DET_BITS'(med2);

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.pick) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pick) begin
      detrended_half <= det;
      median_twice   <= med2;
    end
  end

  // Status
  assign stat.full       = (fill >= (CNT_W'(span) + CNT_W'(1)));
  assign stat.sort_last  = (step == SPAN_W'(DEPTH - 1));
  assign stat.align_done = (step == half);
  assign stat.out_free   = !out_valid || out_ready;

endmodule

[rtl/sliding_median_detrend.sv]
// Sliding-median detrender.
// Input channel (in_valid/in_ready): one signed sample per request plus a
// new_block flag that restarts the window fill with that sample.
// Output channel (out_valid/out_ready): detrended_half = 2*sample - median_twice,
// where median_twice is the sum of the two middle values of the window (the
// current sample and the window_span samples before it), or twice the middle.
// No result is given until the window of the current block is full.
// cfg_we/cfg_wdata write window_span; values above MAX_SPAN saturate.
// Timing: after the accept edge the check state tests the fill. A sample that
// gives no result then leaves the block ready again. Otherwise MAX_SPAN+1
// odd-even sort passes follow, then window_span/2 (rounded down) shift steps
// and a final check to find the middle pair at the front, then the output
// register is loaded and the block returns to ready for the next sample.
// The block takes no new sample while one is still in these steps.
// The output register lets the next sample be taken while a result waits;
// if the receiver stalls, the next result holds in its final step.
// Reset (rst, synchronous) empties the window fill, drops a pending result
// and sets window_span to 4.
module sliding_median_detrend #(
  parameter int MAX_SPAN    = smd_pkg::MAX_SPAN_DEF,
  parameter int SAMPLE_BITS = smd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [smd_pkg::CFG_BITS-1:0]  cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic                          new_block,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS+1:0] detrended_half,
  output logic signed [SAMPLE_BITS:0]   median_twice
);
  import smd_pkg::*;

  smd_cmd_t  cmd;
  smd_stat_t stat;

  // Sequencer
  smd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Window, sort array and output register
  smd_dp #(
    .MAX_SPAN    (MAX_SPAN),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .sample         (sample),
    .new_block      (new_block),
    .cmd            (cmd),
    .stat           (stat),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .detrended_half (detrended_half),
    .median_twice   (median_twice)
  );

endmodule

[tb/smd_checker.sv]
`timescale 1ns / 100ps

// Watches both channels and the span register write port. Predicts each
// detrended result from the accepted samples and compares in order.
module smd_checker #(
  parameter int MAX_SPAN    = smd_pkg::MAX_SPAN_DEF,
  parameter int SAMPLE_BITS = smd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [smd_pkg::CFG_BITS-1:0]  cfg_wdata,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic                          new_block,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic signed [SAMPLE_BITS+1:0] detrended_half,
  input  logic signed [SAMPLE_BITS:0]   median_twice,
  output int                            mismatch_count,
  output int                            pending_count
);

  typedef struct packed {
    logic signed [SAMPLE_BITS+1:0] det;
    logic signed [SAMPLE_BITS:0]   med;
  } detrend_t;

  // Model copy of the window (entry 0 newest), fill level and span
  logic signed [SAMPLE_BITS-1:0] window_hist [0:MAX_SPAN];
  int                            fill_cnt;
  int                            span_cur;
  detrend_t                      expected_detrend [$];
  detrend_t                      want;

  initial begin
    mismatch_count = 0;
    pending_count  = 0;
    fill_cnt       = 0;
    span_cur       = smd_pkg::SPAN_RESET;
  end

  // Shift one sample in; queue a result once the window is full
  task automatic detrend_sample(input logic signed [SAMPLE_BITS-1:0] s, input logic nb);
    longint   ordered [0:MAX_SPAN];
    longint   v;
    longint   med2;
    longint   det;
    int       n;
    int       i;
    int       j;
    detrend_t r;
    if (nb) fill_cnt = 0;
    for (i = MAX_SPAN; i > 0; i--) window_hist[i] = window_hist[i-1];
    window_hist[0] = s;
    if (fill_cnt < MAX_SPAN + 1) fill_cnt++;
    n = span_cur + 1;
    if (fill_cnt < n) return;
    // insertion sort of the live window
    for (i = 0; i < n; i++) begin
      v = window_hist[i];
      j = i;
      while (j > 0 && ordered[j-1] > v) begin
        ordered[j] = ordered[j-1];
        j--;
      end
      ordered[j] = v;
    end
    if (n % 2 == 1) begin
      med2 = 2 * ordered[n/2];
    end else begin
      med2 = ordered[n/2-1] + ordered[n/2];
    end
    det = 2 * longint'(s) - med2;
    r.det = det[SAMPLE_BITS+1:0];
    r.med = med2[SAMPLE_BITS:0];
    expected_detrend.push_back(r);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      fill_cnt = 0;
      span_cur = smd_pkg::SPAN_RESET;
      expected_detrend.delete();
    end else begin
      // results leaving the block
      if (out_valid && out_ready) begin
        if (expected_detrend.size() == 0) begin
          $error("unexpected result: detrended_half %0d, median_twice %0d",
                 detrended_half, median_twice);
          mismatch_count++;
        end else begin
          want = expected_detrend.pop_front();
          if (detrended_half !== want.det) begin
            $error("detrended_half: expected %0d, got %0d", want.det, detrended_half);
            mismatch_count++;
          end
          if (median_twice !== want.med) begin
            $error("median_twice: expected %0d, got %0d", want.med, median_twice);
            mismatch_count++;
          end
        end
      end
      // samples entering the block
      if (in_valid && in_ready) detrend_sample(sample, new_block);
      // span register, saturating
      if (cfg_we) span_cur = (cfg_wdata > MAX_SPAN) ? MAX_SPAN : int'(cfg_wdata);
    end
    pending_count = expected_detrend.size();
  end

endmodule

[tb/sliding_median_detrend_tb.sv]
`timescale 1ns / 100ps

module sliding_median_detrend_tb;

  localparam int SB          = smd_pkg::SAMPLE_BITS_DEF;
  localparam int QUIET_LIMIT = 3000;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_ITEMS = 130;

  localparam logic signed [SB-1:0] S_MAX = {1'b0, {(SB-1){1'b1}}};
  localparam logic signed [SB-1:0] S_MIN = {1'b1, {(SB-1){1'b0}}};

  logic                         clk;
  logic                         rst;
  logic                         cfg_we;
  logic [smd_pkg::CFG_BITS-1:0] cfg_wdata;
  logic                         in_valid;
  logic                         in_ready;
  logic signed [SB-1:0]         sample;
  logic                         new_block;
  logic                         out_valid;
  logic                         out_ready;
  logic signed [SB+1:0]         detrended_half;
  logic signed [SB:0]           median_twice;

  int mismatch_count;
  int pending_count;
  int quiet_cycles;
  int results_taken;
  bit in_gaps_on;
  bit ready_free;

  // Span settings per phase; 6 and 7 exercise saturation
  logic [smd_pkg::CFG_BITS-1:0] span_plan [0:7] = '{3'd7, 3'd0, 3'd1, 3'd2,
                                                     3'd3, 3'd6, 3'd5, 3'd4};

  sliding_median_detrend uut (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .sample         (sample),
    .new_block      (new_block),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .detrended_half (detrended_half),
    .median_twice   (median_twice)
  );

  smd_checker detrend_check (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .sample         (sample),
    .new_block      (new_block),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .detrended_half (detrended_half),
    .median_twice   (median_twice),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Watchdog: too long with no request moving on either side
  initial quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst || cfg_we || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("sliding_median_detrend test failed");
      $finish;
    end
  end

  // Results taken, drives the one long receiver hold-off
  initial results_taken = 0;
  always @(posedge clk) begin
    if (out_valid && out_ready) results_taken <= results_taken + 1;
  end

  // Receiver: random stalls, one long hold-off so the block backs up
  initial begin
    bit held;
    held      = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && results_taken >= 200) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if ($urandom_range(0, 149) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(10, 40)) @(negedge clk);
      end else begin
        out_ready <= ready_free || ($urandom_range(0, 3) != 0);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (!in_gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Extremes, small values with ties, and full-range values
  function automatic logic signed [SB-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return S_MAX;
      1: return S_MIN;
      2, 3, 4: return SB'($signed($urandom_range(0, 16)) - 8);
      default: return SB'($urandom);
    endcase
  endfunction

  // Called and returns at a falling edge
  task automatic send_sample(input logic signed [SB-1:0] s, input logic nb);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    sample    <= s;
    new_block <= nb;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Drop valid and let every pending result and the datapath drain
  task automatic drain_block();
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_span(input logic [smd_pkg::CFG_BITS-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    rst        = 1'b1;
    cfg_we     = 1'b0;
    cfg_wdata  = '0;
    in_valid   = 1'b0;
    sample     = '0;
    new_block  = 1'b0;
    in_gaps_on = 1'b1;
    ready_free = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed, reset span of 4: largest positive swing
    send_sample(S_MIN, 1'b1);
    repeat (3) send_sample(S_MIN, 1'b0);
    send_sample(S_MAX, 1'b0);
    // window turns over to all max, then largest negative swing
    repeat (4) send_sample(S_MAX, 1'b0);
    send_sample(S_MIN, 1'b0);
    // new block flagged part way through the fill
    send_sample(24'sd0, 1'b1);
    send_sample(-24'sd1, 1'b0);
    send_sample(24'sd1, 1'b1);
    send_sample(24'sd2, 1'b0);
    send_sample(-24'sd1, 1'b0);
    send_sample(24'sd0, 1'b0);
    send_sample(24'sd5, 1'b0);
    // ties around the middle
    send_sample(24'sd100, 1'b1);
    send_sample(24'sd100, 1'b0);
    send_sample(-24'sd100, 1'b0);
    send_sample(-24'sd100, 1'b0);
    send_sample(24'sd0, 1'b0);

    // Random phases, one span setting each; fill carries across phases
    for (int p = 0; p < 8; p++) begin
      drain_block();
      write_span(span_plan[p]);
      in_gaps_on = ($urandom_range(0, 3) != 0);
      ready_free = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        send_sample(pick_sample(), $urandom_range(0, 29) == 0);
      end
    end

    drain_block();
    if (mismatch_count == 0) begin
      $display("sliding_median_detrend test passed");
    end else begin
      $display("sliding_median_detrend test failed");
    end
    $finish;
  end

endmodule
